FILE: design/boc_pkg.sv
`default_nettype none

package boc_pkg;

	localparam int IOU_W      = 17;
	localparam int DIST_W     = 18;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 1;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage

`default_nettype wire

FILE: design/boc_geom.sv
`default_nettype none

module boc_geom #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [COORD_BITS-1:0]     ref_x,
	input  wire logic [COORD_BITS-1:0]     ref_y,
	input  wire logic [COORD_BITS-1:0]     ref_w,
	input  wire logic [COORD_BITS-1:0]     ref_h,
	input  wire logic [COORD_BITS-1:0]     pred_x,
	input  wire logic [COORD_BITS-1:0]     pred_y,
	input  wire logic [COORD_BITS-1:0]     pred_w,
	input  wire logic [COORD_BITS-1:0]     pred_h,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [2*COORD_BITS:0]          uni,
	output logic [2*COORD_BITS-1:0]        inter,
	output logic [2*COORD_BITS+2:0]        sq,
	output logic                           empty
);
	import boc_pkg::*;

	localparam int C = COORD_BITS;

	function automatic logic [C-1:0] span_ovl(input logic [C-1:0] a0, input logic [C-1:0] al,
		input logic [C-1:0] b0, input logic [C-1:0] bl);
		logic [C:0] lo, hi, ae, be;
		lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
		ae = {1'b0, a0} + {1'b0, al};
		be = {1'b0, b0} + {1'b0, bl};
		hi = (ae < be) ? ae : be;
		return (hi > lo) ? C'(hi - lo) : '0;
	endfunction

	function automatic logic [C:0] center(input logic [C-1:0] x, input logic [C-1:0] w);
		logic [C-1:0] k;
		k = w >> 1;
		if (w[0] && k[0]) begin
			k = k + C'(1);
		end
		return {1'b0, x} + {1'b0, k};
	endfunction

	logic rdy1, rdy2, rdy3;
	logic v_s1, v_s2, v_s3;

	logic [C:0] rcx, rcy, pcx, pcy;

	logic [C-1:0] ovx_s1, ovy_s1, rw_s1, rh_s1, pw_s1, ph_s1;
	logic [C:0]   dx_s1, dy_s1;

	logic [2*C-1:0] ar_s2, ap_s2, inter_s2;
	logic [2*C+1:0] dx2_s2, dy2_s2;

	logic [2*C:0]   uni_s3;
	logic [2*C-1:0] inter_s3;
	logic [2*C+2:0] sq_s3;
	logic           empty_s3;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign rcx = center(ref_x, ref_w);
	assign rcy = center(ref_y, ref_h);
	assign pcx = center(pred_x, pred_w);
	assign pcy = center(pred_y, pred_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// spans, centers and center offsets
	always_ff @(posedge clk) begin
		if (rdy1) begin
			ovx_s1 <= span_ovl(ref_x, ref_w, pred_x, pred_w);
			ovy_s1 <= span_ovl(ref_y, ref_h, pred_y, pred_h);
			dx_s1  <= (rcx > pcx) ? rcx - pcx : pcx - rcx;
			dy_s1  <= (rcy > pcy) ? rcy - pcy : pcy - rcy;
			rw_s1  <= ref_w;
			rh_s1  <= ref_h;
			pw_s1  <= pred_w;
			ph_s1  <= pred_h;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (rdy2) begin
			ar_s2    <= (2*C)'(rw_s1) * (2*C)'(rh_s1);
			ap_s2    <= (2*C)'(pw_s1) * (2*C)'(ph_s1);
			inter_s2 <= (2*C)'(ovx_s1) * (2*C)'(ovy_s1);
			dx2_s2   <= (2*C+2)'(dx_s1) * (2*C+2)'(dx_s1);
			dy2_s2   <= (2*C+2)'(dy_s1) * (2*C+2)'(dy_s1);
		end
	end

	// union and squared distance
	always_ff @(posedge clk) begin
		if (rdy3) begin
			uni_s3   <= (2*C+1)'(ar_s2) + (2*C+1)'(ap_s2) - (2*C+1)'(inter_s2);
			inter_s3 <= inter_s2;
			sq_s3    <= (2*C+3)'(dx2_s2) + (2*C+3)'(dy2_s2);
			empty_s3 <= (ar_s2 == '0) && (ap_s2 == '0);
		end
	end

	assign out_valid = v_s3;
	assign uni       = uni_s3;
	assign inter     = inter_s3;
	assign sq        = sq_s3;
	assign empty     = empty_s3;

endmodule

`default_nettype wire

FILE: design/boc_divsqrt.sv
`default_nettype none

module boc_divsqrt #(
	parameter int COORD_BITS     = 12,
	parameter int IOU_FRAC_BITS  = 16,
	parameter int DIST_FRAC_BITS = 4
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [2*COORD_BITS:0]     uni,
	input  wire logic [2*COORD_BITS-1:0]   inter,
	input  wire logic [2*COORD_BITS+2:0]   sq,
	input  wire logic                      empty,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [boc_pkg::IOU_W-1:0]      iou,
	output logic [boc_pkg::DIST_W-1:0]     center_dist,
	output logic                           empty_union
);
	import boc_pkg::*;

	localparam int AW   = 2*COORD_BITS + 1;
	localparam int SW   = 2*COORD_BITS + 3;
	localparam int QB   = IOU_FRAC_BITS + 1;
	localparam int RADW = SW + 2*DIST_FRAC_BITS;
	localparam int RW2  = RADW + (RADW % 2);
	localparam int RB   = RW2 / 2;
	localparam int N    = (QB > RB) ? QB : RB;
	localparam int IW   = (QB > IOU_W) ? QB : IOU_W;
	localparam int DW   = (RB > DIST_W) ? RB : DIST_W;

	logic           rdy [N+1];
	logic           v_s [N];
	logic [AW-1:0]  d_s [N];
	logic [AW-1:0]  rem_s [N];
	logic [QB-1:0]  quo_s [N];
	logic [RW2-1:0] rad_s [N];
	logic [RB:0]    srem_s [N];
	logic [RB-1:0]  root_s [N];
	logic           e_s [N];

	logic [IW-1:0]  quo_x;
	logic [DW-1:0]  root_x;

	assign rdy[N]   = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < N; k++) begin : g_st
		logic [AW-1:0]  d_in, r_in, r_nx;
		logic [QB-1:0]  q_in, q_nx;
		logic [RW2-1:0] rad_in, rad_nx;
		logic [RB:0]    sr_in, sr_nx;
		logic [RB-1:0]  root_in, root_nx;
		logic           v_in, e_in;

		assign rdy[k] = !v_s[k] || rdy[k+1];

		if (k == 0) begin : g_head
			assign v_in    = in_valid;
			assign d_in    = uni;
			assign r_in    = AW'(inter);
			assign q_in    = '0;
			assign rad_in  = RW2'(sq) << (2*DIST_FRAC_BITS);
			assign sr_in   = '0;
			assign root_in = '0;
			assign e_in    = empty;
		end else begin : g_link
			assign v_in    = v_s[k-1];
			assign d_in    = d_s[k-1];
			assign r_in    = rem_s[k-1];
			assign q_in    = quo_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign sr_in   = srem_s[k-1];
			assign root_in = root_s[k-1];
			assign e_in    = e_s[k-1];
		end

		// restoring divide, one quotient bit
		if (k < QB) begin : g_div
			logic [AW:0] t;
			logic        ge;
			if (k == 0) begin : g_first
				assign t = {1'b0, r_in};
			end else begin : g_next
				assign t = {r_in, 1'b0};
			end
			assign ge   = t >= {1'b0, d_in};
			assign r_nx = ge ? AW'(t - {1'b0, d_in}) : t[AW-1:0];
			assign q_nx = {q_in[QB-2:0], ge};
		end else begin : g_div_pass
			assign r_nx = r_in;
			assign q_nx = q_in;
		end

		// digit-by-digit square root, one root bit
		if (k < RB) begin : g_sqrt
			logic [RB+2:0] t;
			logic [RB+2:0] trial;
			logic          ge;
			assign t       = {sr_in, rad_in[RW2-1 -: 2]};
			assign trial   = {1'b0, root_in, 2'b01};
			assign ge      = t >= trial;
			assign sr_nx   = ge ? (RB+1)'(t - trial) : t[RB:0];
			assign root_nx = {root_in[RB-2:0], ge};
			assign rad_nx  = rad_in << 2;
		end else begin : g_sqrt_pass
			assign sr_nx   = sr_in;
			assign root_nx = root_in;
			assign rad_nx  = rad_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				d_s[k]    <= d_in;
				rem_s[k]  <= r_nx;
				quo_s[k]  <= q_nx;
				rad_s[k]  <= rad_nx;
				srem_s[k] <= sr_nx;
				root_s[k] <= root_nx;
				e_s[k]    <= e_in;
			end
		end
	end

	assign quo_x  = IW'(quo_s[N-1]);
	assign root_x = DW'(root_s[N-1]);

	assign out_valid   = v_s[N-1];
	assign empty_union = e_s[N-1];
	assign iou         = e_s[N-1] ? '0 : quo_x[IOU_W-1:0];
	assign center_dist = (root_x > DW'(DIST_MAX)) ? DIST_MAX : root_x[DIST_W-1:0];

endmodule

`default_nettype wire

FILE: design/box_overlap_and_center_distance_core.sv
// root bits: half of (2*COORD_BITS + 3 + 2*DIST_FRAC_BITS), rounded up
// throughput: one word per cycle unless m_axis_tready stalls the output,
// one divider stage and one root stage per result bit
// reset: arst_n clears only the stage valid bits; data registers are not reset
`default_nettype none

module box_overlap_and_center_distance_core #(
	parameter int COORD_BITS     = 12,
	parameter int IOU_FRAC_BITS  = 16,
	parameter int DIST_FRAC_BITS = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// ref_x, ref_y, ref_w, ref_h, pred_x, pred_y, pred_w, pred_h
	input  wire logic [8*COORD_BITS-1:0]            s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// iou, center_dist, zero fill
	output logic [boc_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	// empty_union
	output logic [boc_pkg::OUT_USER_W-1:0]          m_axis_tuser
);
	import boc_pkg::*;

	localparam int C = COORD_BITS;

	logic           g_valid, g_ready;
	logic [2*C:0]   g_uni;
	logic [2*C-1:0] g_inter;
	logic [2*C+2:0] g_sq;
	logic           g_empty;

	logic [IOU_W-1:0]  iou;
	logic [DIST_W-1:0] center_dist;
	logic              empty_union;

	boc_geom #(
		.COORD_BITS(COORD_BITS)
	) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.ref_x    (s_axis_tdata[0*C +: C]),
		.ref_y    (s_axis_tdata[1*C +: C]),
		.ref_w    (s_axis_tdata[2*C +: C]),
		.ref_h    (s_axis_tdata[3*C +: C]),
		.pred_x   (s_axis_tdata[4*C +: C]),
		.pred_y   (s_axis_tdata[5*C +: C]),
		.pred_w   (s_axis_tdata[6*C +: C]),
		.pred_h   (s_axis_tdata[7*C +: C]),
		.out_valid(g_valid),
		.out_ready(g_ready),
		.uni      (g_uni),
		.inter    (g_inter),
		.sq       (g_sq),
		.empty    (g_empty)
	);

	boc_divsqrt #(
		.COORD_BITS    (COORD_BITS),
		.IOU_FRAC_BITS (IOU_FRAC_BITS),
		.DIST_FRAC_BITS(DIST_FRAC_BITS)
	) u_divsqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (g_valid),
		.in_ready   (g_ready),
		.uni        (g_uni),
		.inter      (g_inter),
		.sq         (g_sq),
		.empty      (g_empty),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.iou        (iou),
		.center_dist(center_dist),
		.empty_union(empty_union)
	);

	assign m_axis_tdata = OUT_DATA_W'({center_dist, iou});
	assign m_axis_tuser = empty_union;

	// input stalls only when every stage is full and the output is held
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

	// an empty union never carries a nonzero overlap
	a_empty_iou_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[IOU_W-1:0] == '0))
		else $error("nonzero overlap on empty union");

	// a full pipeline with a ready output frees the input in the same cycle
	a_ready_when_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input blocked while output drains");

endmodule

`default_nettype wire
